[src/cubic_bezier_easing_map_assert.svh]
// Assertion macros used by the cubic Bezier easing map controller.
`ifndef CUBIC_BEZIER_EASING_MAP_ASSERT_SVH
`define CUBIC_BEZIER_EASING_MAP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define CBE_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("cbe: assertion failed");

// next-cycle implication, checked out of reset
`define CBE_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("cbe: assertion failed");

`endif

[src/cbe_pkg.sv]
// Types and constants of the cubic Bezier easing map.
package cbe_pkg;

  localparam int unsigned FracBits = 16;
  localparam int          OneInt   = 1 << FracBits;
  localparam int unsigned InW      = 18;
  localparam int unsigned OutW     = 24;
  localparam int unsigned XW       = 17;
  localparam int unsigned YW       = 20;
  localparam int unsigned CoefW    = 26;
  localparam int unsigned DataW    = 34;
  localparam int unsigned ProdW    = 2 * DataW;
  localparam int unsigned DivNumW  = DataW + FracBits;
  localparam int unsigned BitIdxW  = $clog2(FracBits + 1);
  localparam int unsigned ApbDW    = 32;
  localparam int unsigned ApbAW    = 4;
  localparam int          LineTol  = 16;
  localparam int          FTol     = 3;

  typedef enum logic [1:0] {
    REG_CTRL1_X = 2'd0,
    REG_CTRL1_Y = 2'd1,
    REG_CTRL2_X = 2'd2,
    REG_CTRL2_Y = 2'd3
  } reg_idx_e;

  typedef enum logic {
    REQ_Y_FROM_X = 1'b0,
    REQ_POINT    = 1'b1
  } req_e;

  typedef struct packed {
    logic [XW-1:0] ctrl1_x;
    logic [YW-1:0] ctrl1_y;
    logic [XW-1:0] ctrl2_x;
    logic [YW-1:0] ctrl2_y;
  } cfg_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL,
    OP_ACC,
    OP_NUM,
    OP_DEN1,
    OP_DEN2,
    OP_DIV,
    OP_TUPD,
    OP_TZERO,
    OP_CUBE,
    OP_OUTX,
    OP_OUTY,
    OP_OUTY_X
  } dp_op_e;

  typedef enum logic [3:0] {
    SRC_T,
    SRC_ACC,
    SRC_A,
    SRC_A3,
    SRC_A6,
    SRC_FP,
    SRC_F,
    SRC_FPP,
    SRC_CAND
  } src_e;

  typedef enum logic [2:0] {
    ADD_ZERO,
    ADD_B,
    ADD_B2,
    ADD_C,
    ADD_NEGX
  } add_e;

  typedef enum logic [1:0] {
    DST_ACC,
    DST_F,
    DST_FP,
    DST_FPP
  } dst_e;

  typedef struct packed {
    dp_op_e             op;
    src_e               src_a;
    src_e               src_b;
    add_e               addend;
    dst_e               dst;
    logic               set_y;
    logic [BitIdxW-1:0] bit_idx;
  } dp_cmd_t;

  typedef struct packed {
    logic req_point;
    logic shortcut;
    logic cube;
    logic f_small;
    logic den_zero;
    logic div_busy;
  } dp_stat_t;

endpackage

[src/cbe_regs.sv]
// APB configuration registers of the easing map.
module cbe_regs
  import cbe_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel_i,
  input  logic             penable_i,
  input  logic             pwrite_i,
  input  logic [ApbAW-1:0] paddr_i,
  input  logic [ApbDW-1:0] pwdata_i,
  output logic [ApbDW-1:0] prdata_o,
  output cfg_t             cfg_o
);

  logic [XW-1:0] ctrl1_x_q, ctrl2_x_q;
  logic [YW-1:0] ctrl1_y_q, ctrl2_y_q;
  logic          wr_en;
  reg_idx_e      idx;

  assign wr_en = psel_i && penable_i && pwrite_i;
  assign idx   = reg_idx_e'(paddr_i[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl1_x_q <= '0;
      ctrl1_y_q <= '0;
      ctrl2_x_q <= XW'(OneInt);
      ctrl2_y_q <= YW'(OneInt);
    end else if (wr_en) begin
      unique case (idx)
        REG_CTRL1_X: ctrl1_x_q <= pwdata_i[XW-1:0];
        REG_CTRL1_Y: ctrl1_y_q <= pwdata_i[YW-1:0];
        REG_CTRL2_X: ctrl2_x_q <= pwdata_i[XW-1:0];
        REG_CTRL2_Y: ctrl2_y_q <= pwdata_i[YW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_CTRL1_X: prdata_o = {{(ApbDW-XW){1'b0}}, ctrl1_x_q};
      REG_CTRL1_Y: prdata_o = {{(ApbDW-YW){1'b0}}, ctrl1_y_q};
      REG_CTRL2_X: prdata_o = {{(ApbDW-XW){1'b0}}, ctrl2_x_q};
      REG_CTRL2_Y: prdata_o = {{(ApbDW-YW){1'b0}}, ctrl2_y_q};
      default:     prdata_o = '0;
    endcase
  end

  assign cfg_o.ctrl1_x = ctrl1_x_q;
  assign cfg_o.ctrl1_y = ctrl1_y_q;
  assign cfg_o.ctrl2_x = ctrl2_x_q;
  assign cfg_o.ctrl2_y = ctrl2_y_q;

endmodule

[src/cbe_div.sv]
// Serial restoring signed divider, one quotient bit per cycle, truncating.
module cbe_div
  import cbe_pkg::*;
#(
  parameter int unsigned NumW = 50,
  parameter int unsigned DenW = 34
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic signed [NumW-1:0] num_i,
  input  logic signed [DenW-1:0] den_i,
  output logic                   busy_o,
  output logic signed [NumW:0]   quo_o
);

  localparam int unsigned CntW = $clog2(NumW + 1);

  logic            busy_q;
  logic [CntW-1:0] cnt_q;
  logic [DenW-1:0] rem_q;
  logic [DenW-1:0] dmag_q;
  logic [NumW-1:0] quo_q;
  logic            neg_q;
  logic [DenW:0]   rem_sh;
  logic            fits;

  assign rem_sh = {rem_q, quo_q[NumW-1]};
  assign fits   = rem_sh >= {1'b0, dmag_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CntW'(NumW);
    end else if (busy_q) begin
      cnt_q  <= cnt_q - CntW'(1);
      busy_q <= cnt_q != CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q  <= num_i[NumW-1] ? NumW'(-num_i) : num_i;
      dmag_q <= den_i[DenW-1] ? DenW'(-den_i) : den_i;
      rem_q  <= '0;
      neg_q  <= num_i[NumW-1] ^ den_i[DenW-1];
    end else if (busy_q) begin
      rem_q <= fits ? DenW'(rem_sh - {1'b0, dmag_q}) : rem_sh[DenW-1:0];
      quo_q <= {quo_q[NumW-2:0], fits};
    end
  end

  assign busy_o = busy_q;
  assign quo_o  = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});

endmodule

[src/cbe_dp.sv]
// Datapath: coefficients, shared multiplier, accumulator, Halley and cube-root registers.
module cbe_dp
  import cbe_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cfg_t                   cfg_i,
  input  logic                   req_type_i,
  input  logic signed [InW-1:0]  in_value_i,
  input  dp_cmd_t                cmd_i,
  output dp_stat_t               stat_o,
  output logic signed [OutW-1:0] out_x_o,
  output logic signed [OutW-1:0] out_y_o
);

  localparam int unsigned TnW = DivNumW + 2;
  localparam logic signed [DataW-1:0] OneD    = DataW'(OneInt);
  localparam logic signed [InW-1:0]   OneIn   = InW'(OneInt);
  localparam logic signed [TnW-1:0]   OneT    = TnW'(OneInt);
  localparam logic signed [DataW-1:0] TolD    = DataW'(LineTol);
  localparam logic signed [DataW-1:0] FTolD   = DataW'(FTol);
  localparam logic signed [DataW-1:0] OutMaxD = DataW'(2 ** (OutW - 1) - 1);
  localparam logic signed [DataW-1:0] OutMinD = -DataW'(2 ** (OutW - 1));

  logic signed [DataW-1:0] p1x, p2x, p1y, p2y, d1, d2;
  logic signed [DataW-1:0] ax_w, bx_w, cx_w, ay_w, by_w, cy_w;
  logic signed [InW-1:0]   v_clamp;

  logic                    req_q;
  logic signed [InW-1:0]   x_q, t_q;
  logic signed [CoefW-1:0] ax_q, bx_q, cx_q, ay_q, by_q, cy_q, a3x_q, a6x_q, b2x_q;
  logic signed [DataW-1:0] acc_q, f_q, fp_q, fpp_q, num_q, den_q;
  logic signed [ProdW-1:0] prod_q;
  logic signed [OutW-1:0]  out_x_q, out_y_q;

  logic signed [DataW-1:0] opa, opb, addend, cand, prod_fr, prod_fr2, acc_sum;
  logic signed [ProdW-1:0] prod_sh, prod_x2, prod_sh2, xsh;
  logic signed [DivNumW:0] quo;
  logic signed [TnW-1:0]   t_new;
  logic                    div_busy;
  logic                    near_line, endpoint;

  // clamped control points and polynomial coefficients
  always_comb begin
    p1x  = (cfg_i.ctrl1_x > XW'(OneInt)) ? OneD : DataW'(cfg_i.ctrl1_x);
    p2x  = (cfg_i.ctrl2_x > XW'(OneInt)) ? OneD : DataW'(cfg_i.ctrl2_x);
    p1y  = DataW'($signed(cfg_i.ctrl1_y));
    p2y  = DataW'($signed(cfg_i.ctrl2_y));
    ax_w = OneD + (p1x <<< 1) + p1x - (p2x <<< 1) - p2x;
    bx_w = (p2x <<< 1) + p2x - (p1x <<< 2) - (p1x <<< 1);
    cx_w = (p1x <<< 1) + p1x;
    ay_w = OneD + (p1y <<< 1) + p1y - (p2y <<< 1) - p2y;
    by_w = (p2y <<< 1) + p2y - (p1y <<< 2) - (p1y <<< 1);
    cy_w = (p1y <<< 1) + p1y;
    d1   = p1x - p1y;
    d2   = p2x - p2y;
    if (in_value_i < 0) begin
      v_clamp = '0;
    end else if (in_value_i > OneIn) begin
      v_clamp = OneIn;
    end else begin
      v_clamp = in_value_i;
    end
  end

  assign near_line = (d1 <= TolD) && (d1 >= -TolD) && (d2 <= TolD) && (d2 >= -TolD);
  assign endpoint  = (x_q == '0) || (x_q == OneIn);

  assign cand = DataW'(t_q) | (DataW'(1) << cmd_i.bit_idx);

  always_comb begin
    case (cmd_i.src_a)
      SRC_T:    opa = DataW'(t_q);
      SRC_ACC:  opa = acc_q;
      SRC_A:    opa = cmd_i.set_y ? DataW'(ay_q) : DataW'(ax_q);
      SRC_A3:   opa = DataW'(a3x_q);
      SRC_A6:   opa = DataW'(a6x_q);
      SRC_FP:   opa = fp_q;
      SRC_F:    opa = f_q;
      SRC_FPP:  opa = fpp_q;
      SRC_CAND: opa = cand;
      default:  opa = '0;
    endcase
    case (cmd_i.src_b)
      SRC_T:    opb = DataW'(t_q);
      SRC_ACC:  opb = acc_q;
      SRC_A:    opb = cmd_i.set_y ? DataW'(ay_q) : DataW'(ax_q);
      SRC_A3:   opb = DataW'(a3x_q);
      SRC_A6:   opb = DataW'(a6x_q);
      SRC_FP:   opb = fp_q;
      SRC_F:    opb = f_q;
      SRC_FPP:  opb = fpp_q;
      SRC_CAND: opb = cand;
      default:  opb = '0;
    endcase
    case (cmd_i.addend)
      ADD_ZERO: addend = '0;
      ADD_B:    addend = cmd_i.set_y ? DataW'(by_q) : DataW'(bx_q);
      ADD_B2:   addend = DataW'(b2x_q);
      ADD_C:    addend = cmd_i.set_y ? DataW'(cy_q) : DataW'(cx_q);
      ADD_NEGX: addend = -DataW'(x_q);
      default:  addend = '0;
    endcase
  end

  // floor shifts of the product
  assign prod_sh  = prod_q >>> FracBits;
  assign prod_fr  = prod_sh[DataW-1:0];
  assign prod_x2  = prod_q <<< 1;
  assign prod_sh2 = prod_x2 >>> FracBits;
  assign prod_fr2 = prod_sh2[DataW-1:0];
  assign acc_sum  = prod_fr + addend;
  assign xsh      = ProdW'(x_q) <<< FracBits;
  assign t_new    = TnW'(t_q) - TnW'(quo);

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_LOAD: begin
        req_q   <= req_type_i;
        x_q     <= v_clamp;
        t_q     <= (req_type_i == REQ_POINT) ? in_value_i : v_clamp;
        out_x_q <= OutW'(v_clamp);
        ax_q    <= ax_w[CoefW-1:0];
        bx_q    <= bx_w[CoefW-1:0];
        cx_q    <= cx_w[CoefW-1:0];
        ay_q    <= ay_w[CoefW-1:0];
        by_q    <= by_w[CoefW-1:0];
        cy_q    <= cy_w[CoefW-1:0];
        a3x_q   <= CoefW'((ax_w <<< 1) + ax_w);
        a6x_q   <= CoefW'((ax_w <<< 2) + (ax_w <<< 1));
        b2x_q   <= CoefW'(bx_w <<< 1);
      end
      OP_MUL: prod_q <= opa * opb;
      OP_ACC: begin
        case (cmd_i.dst)
          DST_ACC: acc_q <= acc_sum;
          DST_F:   f_q   <= acc_sum;
          DST_FP:  fp_q  <= acc_sum;
          DST_FPP: fpp_q <= acc_sum;
          default: acc_q <= acc_sum;
        endcase
      end
      OP_NUM:  num_q <= prod_fr2;
      OP_DEN1: den_q <= prod_fr2;
      OP_DEN2: den_q <= den_q - prod_fr;
      OP_TUPD: begin
        if (t_new < 0) begin
          t_q <= '0;
        end else if (t_new > OneT) begin
          t_q <= OneIn;
        end else begin
          t_q <= t_new[InW-1:0];
        end
      end
      OP_TZERO: t_q <= '0;
      OP_CUBE: begin
        if (cand <= OneD && prod_q <= xsh) begin
          t_q <= cand[InW-1:0];
        end
      end
      OP_OUTX: begin
        if (acc_q > OutMaxD) out_x_q <= OutMaxD[OutW-1:0];
        else if (acc_q < OutMinD) out_x_q <= OutMinD[OutW-1:0];
        else out_x_q <= acc_q[OutW-1:0];
      end
      OP_OUTY: begin
        if (acc_q > OutMaxD) out_y_q <= OutMaxD[OutW-1:0];
        else if (acc_q < OutMinD) out_y_q <= OutMinD[OutW-1:0];
        else out_y_q <= acc_q[OutW-1:0];
      end
      OP_OUTY_X: out_y_q <= OutW'(x_q);
      default: ;
    endcase
  end

  cbe_div #(
    .NumW(DivNumW),
    .DenW(DataW)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.op == OP_DIV),
    .num_i  ({num_q, {FracBits{1'b0}}}),
    .den_i  (den_q),
    .busy_o (div_busy),
    .quo_o  (quo)
  );

  assign stat_o.req_point = req_q == REQ_POINT;
  assign stat_o.shortcut  = endpoint || near_line;
  assign stat_o.cube      = (p1x == '0) && (p2x == '0);
  assign stat_o.f_small   = (f_q <= FTolD) && (f_q >= -FTolD);
  assign stat_o.den_zero  = den_q == '0;
  assign stat_o.div_busy  = div_busy;

  assign out_x_o = out_x_q;
  assign out_y_o = out_y_q;

endmodule

[src/cbe_ctrl.sv]
// Controller: sequences polynomial, Halley and cube-root steps on the datapath.
`include "cubic_bezier_easing_map_assert.svh"

module cbe_ctrl
  import cbe_pkg::*;
#(
  parameter int unsigned MaxIterations = 8
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  dp_stat_t stat_i,
  output logic     busy_o,
  output logic     done_o,
  output dp_cmd_t  cmd_o
);

  localparam int unsigned IterW = $clog2(MaxIterations + 1);
  localparam int unsigned NS    = 30;

  typedef enum logic [NS-1:0] {
    S_IDLE = NS'(1) << 0,
    S_DISP = NS'(1) << 1,
    S_PM1  = NS'(1) << 2,
    S_PA1  = NS'(1) << 3,
    S_PM2  = NS'(1) << 4,
    S_PA2  = NS'(1) << 5,
    S_PM3  = NS'(1) << 6,
    S_PA3  = NS'(1) << 7,
    S_OX   = NS'(1) << 8,
    S_OY   = NS'(1) << 9,
    S_FCHK = NS'(1) << 10,
    S_HM1  = NS'(1) << 11,
    S_HA1  = NS'(1) << 12,
    S_HM2  = NS'(1) << 13,
    S_HA2  = NS'(1) << 14,
    S_HM3  = NS'(1) << 15,
    S_HA3  = NS'(1) << 16,
    S_HM4  = NS'(1) << 17,
    S_HA4  = NS'(1) << 18,
    S_HM5  = NS'(1) << 19,
    S_HA5  = NS'(1) << 20,
    S_HM6  = NS'(1) << 21,
    S_HA6  = NS'(1) << 22,
    S_HDZ  = NS'(1) << 23,
    S_HDIV = NS'(1) << 24,
    S_CM1  = NS'(1) << 25,
    S_CA1  = NS'(1) << 26,
    S_CM2  = NS'(1) << 27,
    S_CCMP = NS'(1) << 28,
    S_EMIT = NS'(1) << 29
  } state_e;

  typedef enum logic [1:0] {
    PH_PX,
    PH_PY,
    PH_F,
    PH_Y
  } phase_e;

  state_e             state_q, state_d;
  phase_e             phase_q, phase_d;
  logic [IterW-1:0]   iter_q, iter_d;
  logic [BitIdxW-1:0] bit_q, bit_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      phase_q <= PH_PX;
      iter_q  <= '0;
      bit_q   <= '0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      iter_q  <= iter_d;
      bit_q   <= bit_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    phase_d       = phase_q;
    iter_d        = iter_q;
    bit_d         = bit_q;
    cmd_o.op      = OP_NONE;
    cmd_o.src_a   = SRC_T;
    cmd_o.src_b   = SRC_T;
    cmd_o.addend  = ADD_ZERO;
    cmd_o.dst     = DST_ACC;
    cmd_o.set_y   = (phase_q == PH_PY) || (phase_q == PH_Y);
    cmd_o.bit_idx = bit_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = S_DISP;
        end
      end
      S_DISP: begin
        iter_d = '0;
        if (stat_i.req_point) begin
          phase_d = PH_PX;
          state_d = S_PM1;
        end else if (stat_i.shortcut) begin
          cmd_o.op = OP_OUTY_X;
          state_d  = S_EMIT;
        end else if (stat_i.cube) begin
          cmd_o.op = OP_TZERO;
          bit_d    = BitIdxW'(FracBits);
          state_d  = S_CM1;
        end else begin
          phase_d = PH_F;
          state_d = S_PM1;
        end
      end
      S_PM1: begin
        cmd_o.op    = OP_MUL;
        cmd_o.src_a = SRC_A;
        state_d     = S_PA1;
      end
      S_PA1: begin
        cmd_o.op     = OP_ACC;
        cmd_o.addend = ADD_B;
        state_d      = S_PM2;
      end
      S_PM2: begin
        cmd_o.op    = OP_MUL;
        cmd_o.src_a = SRC_ACC;
        state_d     = S_PA2;
      end
      S_PA2: begin
        cmd_o.op     = OP_ACC;
        cmd_o.addend = ADD_C;
        state_d      = S_PM3;
      end
      S_PM3: begin
        cmd_o.op    = OP_MUL;
        cmd_o.src_a = SRC_ACC;
        state_d     = S_PA3;
      end
      S_PA3: begin
        cmd_o.op = OP_ACC;
        if (phase_q == PH_F) begin
          cmd_o.addend = ADD_NEGX;
          cmd_o.dst    = DST_F;
          state_d      = S_FCHK;
        end else if (phase_q == PH_PX) begin
          state_d = S_OX;
        end else begin
          state_d = S_OY;
        end
      end
      S_OX: begin
        cmd_o.op = OP_OUTX;
        phase_d  = PH_PY;
        state_d  = S_PM1;
      end
      S_OY: begin
        cmd_o.op = OP_OUTY;
        state_d  = S_EMIT;
      end
      S_FCHK: begin
        if (stat_i.f_small) begin
          phase_d = PH_Y;
          state_d = S_PM1;
        end else begin
          state_d = S_HM1;
        end
      end
      S_HM1: begin
        cmd_o.op    = OP_MUL;
        cmd_o.src_a = SRC_A3;
        state_d     = S_HA1;
      end
      S_HA1: begin
        cmd_o.op     = OP_ACC;
        cmd_o.addend = ADD_B2;
        state_d      = S_HM2;
      end
      S_HM2: begin
        cmd_o.op    = OP_MUL;
        cmd_o.src_a = SRC_ACC;
        state_d     = S_HA2;
      end
      S_HA2: begin
        cmd_o.op     = OP_ACC;
        cmd_o.addend = ADD_C;
        cmd_o.dst    = DST_FP;
        state_d      = S_HM3;
      end
      S_HM3: begin
        cmd_o.op    = OP_MUL;
        cmd_o.src_a = SRC_A6;
        state_d     = S_HA3;
      end
      S_HA3: begin
        cmd_o.op     = OP_ACC;
        cmd_o.addend = ADD_B2;
        cmd_o.dst    = DST_FPP;
        state_d      = S_HM4;
      end
      S_HM4: begin
        cmd_o.op    = OP_MUL;
        cmd_o.src_a = SRC_FP;
        cmd_o.src_b = SRC_F;
        state_d     = S_HA4;
      end
      S_HA4: begin
        cmd_o.op = OP_NUM;
        state_d  = S_HM5;
      end
      S_HM5: begin
        cmd_o.op    = OP_MUL;
        cmd_o.src_a = SRC_FP;
        cmd_o.src_b = SRC_FP;
        state_d     = S_HA5;
      end
      S_HA5: begin
        cmd_o.op = OP_DEN1;
        state_d  = S_HM6;
      end
      S_HM6: begin
        cmd_o.op    = OP_MUL;
        cmd_o.src_a = SRC_F;
        cmd_o.src_b = SRC_FPP;
        state_d     = S_HA6;
      end
      S_HA6: begin
        cmd_o.op = OP_DEN2;
        state_d  = S_HDZ;
      end
      S_HDZ: begin
        if (stat_i.den_zero) begin
          phase_d = PH_Y;
          state_d = S_PM1;
        end else begin
          cmd_o.op = OP_DIV;
          state_d  = S_HDIV;
        end
      end
      S_HDIV: begin
        if (!stat_i.div_busy) begin
          cmd_o.op = OP_TUPD;
          state_d  = S_PM1;
          if (iter_q == IterW'(MaxIterations - 1)) begin
            phase_d = PH_Y;
          end else begin
            iter_d = iter_q + IterW'(1);
          end
        end
      end
      S_CM1: begin
        cmd_o.op    = OP_MUL;
        cmd_o.src_a = SRC_CAND;
        cmd_o.src_b = SRC_CAND;
        state_d     = S_CA1;
      end
      S_CA1: begin
        cmd_o.op = OP_ACC;
        state_d  = S_CM2;
      end
      S_CM2: begin
        cmd_o.op    = OP_MUL;
        cmd_o.src_a = SRC_ACC;
        cmd_o.src_b = SRC_CAND;
        state_d     = S_CCMP;
      end
      S_CCMP: begin
        cmd_o.op = OP_CUBE;
        if (bit_q == '0) begin
          phase_d = PH_Y;
          state_d = S_PM1;
        end else begin
          bit_d   = bit_q - BitIdxW'(1);
          state_d = S_CM1;
        end
      end
      S_EMIT: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  assign busy_o = state_q != S_IDLE;
  assign done_o = state_q == S_EMIT;

  `CBE_ASSERT_NEXT(a_accept_busy, start_i && !busy_o, busy_o)
  `CBE_ASSERT_IMPL(a_iter_range, state_q == S_HDIV, iter_q < IterW'(MaxIterations))
  `CBE_ASSERT_NEXT(a_div_launch, cmd_o.op == OP_DIV, stat_i.div_busy)

endmodule

[src/cubic_bezier_easing_map.sv]
// Top level of the cubic Bezier easing map.
//
// Command channel: a transaction is accepted when start is high and busy is
// low; req_type_i selects y-from-x (0) or curve point from t (1), in_value_i
// carries x or t in signed Q.16. busy stays high until the result is out.
// Result: done_o is high for exactly one cycle with out_x_o/out_y_o valid;
// the receiver must take it then, nothing holds it off.
// Configuration: APB port with the two inner control points at byte
// addresses 0, 4, 8 and 12; write only while busy is low.
// Flow: point-from-t evaluates the x and then the y polynomial; the
// y-from-x shortcuts skip the solver. The cube-root path takes 17 passes
// plus a final polynomial. Each Halley step is paced by the serial
// divider and the shared multiplier, up to MaxIterations steps. One
// transaction is in flight at a time.
// Reset: the control points return to (0,0) and (1,1), the block goes idle.
module cubic_bezier_easing_map
  import cbe_pkg::*;
#(
  parameter int unsigned MaxIterations = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  logic                   req_type_i,
  input  logic signed [InW-1:0]  in_value_i,
  output logic                   done_o,
  output logic signed [OutW-1:0] out_x_o,
  output logic signed [OutW-1:0] out_y_o,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [ApbAW-1:0]       paddr,
  input  logic [ApbDW-1:0]       pwdata,
  output logic [ApbDW-1:0]       prdata,
  output logic                   pready
);

  cfg_t     cfg;
  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign pready = 1'b1;

  cbe_regs u_regs (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel_i   (psel),
    .penable_i(penable),
    .pwrite_i (pwrite),
    .paddr_i  (paddr),
    .pwdata_i (pwdata),
    .prdata_o (prdata),
    .cfg_o    (cfg)
  );

  cbe_dp u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .req_type_i(req_type_i),
    .in_value_i(in_value_i),
    .cmd_i     (cmd),
    .stat_o    (stat),
    .out_x_o   (out_x_o),
    .out_y_o   (out_y_o)
  );

  cbe_ctrl #(
    .MaxIterations(MaxIterations)
  ) u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .stat_i (stat),
    .busy_o (busy),
    .done_o (done_o),
    .cmd_o  (cmd)
  );

endmodule
